@@ rtl/normal_equation_accumulator_assert.svh @@
// Assertion macros for the normal-equation accumulator.
`ifndef NORMAL_EQUATION_ACCUMULATOR_ASSERT_SVH
`define NORMAL_EQUATION_ACCUMULATOR_ASSERT_SVH
`define NEA_ASSERT_IMPL(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (b)) else $error("assertion failed");
`define NEA_ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (b)) else $error("assertion failed");
`endif

@@ rtl/nea_pkg.sv @@
// Package of types and constants for the normal-equation accumulator.
`timescale 1ns / 1ps
package nea_pkg;
  localparam int NPAR_DEF = 8;
  localparam int MAX_RES = 45;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACC = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] KIND_OBJ = 2'd0;
  localparam logic [1:0] KIND_GRAD = 2'd1;
  localparam logic [1:0] KIND_CURV = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_MASK = 2'd1;
  localparam logic [1:0] CFG_NACT = 2'd2;
  typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_READ} state_t;
  typedef struct packed {
    logic [1:0] op;
    logic signed [23:0] residual;
    logic signed [23:0] grad_0;
    logic signed [23:0] grad_1;
    logic signed [23:0] grad_2;
    logic signed [23:0] grad_3;
    logic signed [23:0] grad_4;
    logic signed [23:0] grad_5;
    logic signed [23:0] grad_6;
    logic signed [23:0] grad_7;
  } in_item_t;
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] row;
    logic [2:0] col;
    logic signed [63:0] value;
    logic last;
  } out_item_t;
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add = s[63:0];
  endfunction
endpackage

@@ rtl/nea_lane.sv @@
// One multiply lane: a registered signed 24 by 24 product, sign-extended to 64 bits.
`timescale 1ns / 1ps
module nea_lane (
  input  logic               clk,
  input  logic signed [23:0] a,
  input  logic signed [23:0] b,
  output logic signed [63:0] prod_r
);
  logic signed [47:0] p;
  assign p = a * b;
  always_ff @(posedge clk) begin
    prod_r <= {{16{p[47]}}, p};
  end
endmodule

@@ rtl/nea_merge.sv @@
// Merging stage: saturating adds of the lane products into one curvature row.
`timescale 1ns / 1ps
module nea_merge #(
  parameter int NPAR = nea_pkg::NPAR_DEF
) (
  input  logic [NPAR*64-1:0] acc_in,
  input  logic [NPAR*64-1:0] prod_in,
  input  logic [NPAR-1:0]    en,
  output logic [NPAR*64-1:0] acc_out
);
  always_comb begin
    for (int k = 0; k < NPAR; k++) begin
      acc_out[k*64 +: 64] = en[k] ?
        nea_pkg::sat_add(acc_in[k*64 +: 64], prod_in[k*64 +: 64]) : acc_in[k*64 +: 64];
    end
  end
endmodule

@@ rtl/normal_equation_accumulator.sv @@
// Normal-equation accumulator: NPAR lanes add one curvature row a cycle, each entry saturating.
// An accumulate transaction keeps the input closed from acceptance until the accumulators are
// up to date; clear and op 3 leave it open. A readout gives one result a cycle while the sink is
// ready (at most 45), and the input reopens after the last result is taken.
// Synchronous active-low reset clears the accumulators and sets the configuration registers to defaults.
`timescale 1ns / 1ps
module normal_equation_accumulator #(
  parameter int NPAR = nea_pkg::NPAR_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nea_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nea_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);
  localparam int IW = (NPAR > 1) ? $clog2(NPAR) : 1;
  localparam int CW = $clog2(NPAR + 2);
  logic mode_r;
  logic [7:0] mask_r;
  logic [3:0] nact_r;
  nea_pkg::state_t state_r, state_nxt;
  logic signed [63:0] sum_r;
  logic signed [63:0] grad_r [NPAR];
  logic [NPAR*64-1:0] curv_r [NPAR];
  logic signed [23:0] g_r [NPAR];
  logic signed [23:0] res_r;
  logic [CW-1:0] cnt_r;
  logic [3:0] n_used;
  logic [NPAR*64-1:0] prod_v, merged;
  logic [NPAR-1:0] en_v;
  logic [IW-1:0] prow;
  logic pvalid_r;
  logic [IW-1:0] prow_r;
  logic signed [23:0] gsel;
  logic signed [23:0] gin [8];
  logic signed [47:0] rg_p [NPAR];
  // Readout walk.
  logic [1:0] rk_r;
  logic [IW-1:0] ri_r, rj_r;
  logic [5:0] rcnt_r;
  logic ovalid_r;
  logic rd_go;
  nea_pkg::out_item_t od_r;
  logic signed [63:0] sum_half;
  logic signed [47:0] rr_p;
  logic rr_v_r;
  logic signed [63:0] rr_r;

  assign n_used = (nact_r > 4'(NPAR)) ? 4'(NPAR) : nact_r;
  assign gin = '{in_data.grad_0, in_data.grad_1, in_data.grad_2, in_data.grad_3,
                 in_data.grad_4, in_data.grad_5, in_data.grad_6, in_data.grad_7};
  assign prow = cnt_r[IW-1:0];
  assign gsel = g_r[prow];
  assign in_ready = (state_r == nea_pkg::ST_IDLE) && !ovalid_r;
  assign rd_go = (state_r == nea_pkg::ST_READ) && (!ovalid_r || out_ready) &&
                 (rk_r != nea_pkg::KIND_NONE);

  genvar k;
  generate
    for (k = 0; k < NPAR; k++) begin : g_lane
      nea_lane u_lane (.clk(clk), .a(gsel), .b(g_r[k]), .prod_r(prod_v[k*64 +: 64]));
      assign en_v[k] = (k <= int'(prow_r)) && (k < int'(n_used)) && (int'(prow_r) < int'(n_used));
    end
  endgenerate

  nea_merge #(.NPAR(NPAR)) u_merge (
    .acc_in(curv_r[prow_r]), .prod_in(prod_v), .en(en_v), .acc_out(merged));

  assign rr_p = res_r * res_r;

  always_comb begin
    for (int i = 0; i < NPAR; i++) rg_p[i] = res_r * g_r[i];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nea_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.op == nea_pkg::OP_ACC) state_nxt = nea_pkg::ST_ACC;
          else if (in_data.op == nea_pkg::OP_READ) state_nxt = nea_pkg::ST_READ;
        end
      end
      nea_pkg::ST_ACC: if (int'(cnt_r) == NPAR + 1) state_nxt = nea_pkg::ST_IDLE;
      nea_pkg::ST_READ: if (!ovalid_r && rk_r == nea_pkg::KIND_NONE) state_nxt = nea_pkg::ST_IDLE;
      default: state_nxt = nea_pkg::ST_IDLE;
    endcase
  end

  function automatic logic is_free(input logic [7:0] m, input int i);
    is_free = (i >= 8) ? 1'b1 : m[i];
  endfunction

  assign sum_half = {sum_r[63], sum_r[63:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nea_pkg::ST_IDLE;
      mode_r <= 1'b0; mask_r <= 8'hFF; nact_r <= 4'd8;
      sum_r <= '0; cnt_r <= '0; pvalid_r <= 1'b0; rr_v_r <= 1'b0;
      ovalid_r <= 1'b0; rk_r <= nea_pkg::KIND_NONE; rcnt_r <= '0;
      for (int i = 0; i < NPAR; i++) begin grad_r[i] <= '0; curv_r[i] <= '0; end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          nea_pkg::CFG_MODE: mode_r <= cfg_wdata[0];
          nea_pkg::CFG_MASK: mask_r <= cfg_wdata;
          nea_pkg::CFG_NACT: nact_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      pvalid_r <= (state_r == nea_pkg::ST_ACC) && (int'(cnt_r) < NPAR);
      rr_v_r <= (state_r == nea_pkg::ST_ACC) && (cnt_r == '0);
      if (in_valid && in_ready) begin
        res_r <= in_data.residual;
        for (int i = 0; i < NPAR; i++) g_r[i] <= (i < 8) ? gin[i] : 24'sd0;
        cnt_r <= '0;
        if (in_data.op == nea_pkg::OP_CLEAR) begin
          sum_r <= '0;
          for (int i = 0; i < NPAR; i++) begin grad_r[i] <= '0; curv_r[i] <= '0; end
        end
        if (in_data.op == nea_pkg::OP_READ) begin
          rk_r <= nea_pkg::KIND_OBJ; ri_r <= '0; rj_r <= '0; rcnt_r <= '0;
        end
      end
      if (state_r == nea_pkg::ST_ACC) begin
        cnt_r <= cnt_r + 1'b1;
        if (int'(cnt_r) < NPAR) prow_r <= prow;
        if (cnt_r == '0) begin
          rr_r <= {{16{rr_p[47]}}, rr_p};
          for (int i = 0; i < NPAR; i++) begin
            if (i < int'(n_used)) begin
              if (mode_r) grad_r[i] <= nea_pkg::sat_add(grad_r[i],
                                 -({{24{g_r[i][23]}}, g_r[i], 16'd0}));
              else grad_r[i] <= nea_pkg::sat_add(grad_r[i],
                                 {{16{rg_p[i][47]}}, rg_p[i]});
            end
          end
        end
      end
      if (rr_v_r) begin
        if (mode_r) sum_r <= nea_pkg::sat_add(sum_r, -({{24{res_r[23]}}, res_r, 16'd0}));
        else sum_r <= nea_pkg::sat_add(sum_r, rr_r);
      end
      if (pvalid_r) curv_r[prow_r] <= merged;
      // Readout: produce the next result when the output register is empty or its result is being taken.
      if (ovalid_r && out_ready && !rd_go) ovalid_r <= 1'b0;
      if (rd_go) begin
        logic found;
        logic [IW-1:0] ni, nj;
        logic [1:0] nk;
        found = 1'b0;
        ovalid_r <= 1'b1;
        od_r.kind <= rk_r;
        od_r.row <= (rk_r == nea_pkg::KIND_OBJ) ? 3'd0 : 3'(ri_r);
        od_r.col <= (rk_r == nea_pkg::KIND_CURV) ? 3'(rj_r) : 3'd0;
        case (rk_r)
          nea_pkg::KIND_OBJ: od_r.value <= sum_half;
          nea_pkg::KIND_GRAD: od_r.value <= grad_r[ri_r];
          default: od_r.value <= curv_r[ri_r][rj_r*64 +: 64];
        endcase
        // Find the next entry after the one just sent.
        nk = nea_pkg::KIND_NONE; ni = '0; nj = '0;
        if (rk_r == nea_pkg::KIND_OBJ) begin
          if (n_used != 0) begin nk = nea_pkg::KIND_GRAD; ni = '0; found = 1'b1; end
        end else if (rk_r == nea_pkg::KIND_GRAD && int'(ri_r) + 1 < int'(n_used)) begin
          nk = nea_pkg::KIND_GRAD; ni = ri_r + 1'b1; found = 1'b1;
        end
        if (!found && rk_r != nea_pkg::KIND_OBJ) begin
          for (int p = 0; p < NPAR * (NPAR + 1) / 2; p++) begin
            int pi, pj, t;
            t = p; pi = 0;
            for (int q = 0; q < NPAR; q++) if (t > q) begin t = t - q - 1; pi = q + 1; end
            pj = t;
            if (!found && pi < int'(n_used) && is_free(mask_r, pi) && is_free(mask_r, pj) &&
                (rk_r == nea_pkg::KIND_GRAD || pi > int'(ri_r) ||
                 (pi == int'(ri_r) && pj > int'(rj_r)))) begin
              found = 1'b1; nk = nea_pkg::KIND_CURV; ni = IW'(pi); nj = IW'(pj);
            end
          end
        end
        if (int'(rcnt_r) + 1 >= nea_pkg::MAX_RES) nk = nea_pkg::KIND_NONE;
        od_r.last <= (nk == nea_pkg::KIND_NONE);
        rk_r <= nk; ri_r <= ni; rj_r <= nj; rcnt_r <= rcnt_r + 1'b1;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_data = od_r;

  `include "normal_equation_accumulator_assert.svh"
  `NEA_ASSERT_IMPL(a_no_accept_busy, state_r != nea_pkg::ST_IDLE, !in_ready)
  `NEA_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_data.last, !out_valid)
  `NEA_ASSERT_IMPL(a_curv_kind, out_valid && out_data.kind == nea_pkg::KIND_CURV,
                   out_data.col <= out_data.row)
endmodule
